### rtl/lcsw_pkg.sv
// ----------------------------------------------------------------------------
// lcsw_pkg
// Shared types, register codes, colour table and helpers for the link
// congestion send window unit.
// ----------------------------------------------------------------------------
package lcsw_pkg;

    // Link colours
    localparam logic [1:0] COLOUR_GREEN  = 2'd0;
    localparam logic [1:0] COLOUR_YELLOW = 2'd1;
    localparam logic [1:0] COLOUR_RED    = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd0;
    localparam logic [1:0] REG_MIN_SEND_COUNT = 2'd1;
    localparam logic [1:0] REG_MAX_SEND_COUNT = 2'd2;

    // Divider step counts for the two jobs of the shared unit
    localparam logic [5:0] MOD_STEPS = 6'd8;
    localparam logic [5:0] DIV_STEPS = 6'd32;

    localparam int ROW_COUNT = 4;

    typedef struct packed {
        logic [9:0] rtt_limit;
        logic [7:0] green_max;
        logic [7:0] yellow_max;
    } lcsw_row_t;

    localparam lcsw_row_t COLOUR_ROWS [ROW_COUNT] = '{
        '{rtt_limit: 10'd100,  green_max: 8'd15,  yellow_max: 8'd30},
        '{rtt_limit: 10'd300,  green_max: 8'd30,  yellow_max: 8'd50},
        '{rtt_limit: 10'd700,  green_max: 8'd70,  yellow_max: 8'd100},
        '{rtt_limit: 10'd1000, green_max: 8'd100, yellow_max: 8'd150}
    };

    typedef struct packed {
        logic [15:0] round_trip_sample;
        logic [15:0] unacked_sample;
        logic [15:0] pending_sample;
    } lcsw_in_t;

    typedef struct packed {
        logic [15:0] send_count;
        logic [1:0]  link_colour;
        logic        evaluated;
        logic [15:0] min_round_trip;
        logic [15:0] max_round_trip;
        logic [31:0] unacked_total;
        logic [31:0] pending_total;
    } lcsw_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_FINISH
    } lcsw_state_t;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic start_mod;
        logic start_div;
        logic commit;
    } lcsw_ctrl_t;

    // Shared divider status
    typedef struct packed {
        logic busy;
        logic done;
    } lcsw_div_status_t;

    // Saturating 32-bit add of a 16-bit sample
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {17'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Pick the first row whose limit covers the average, last row beyond it
    function automatic logic [1:0] pick_colour(input logic [31:0] avg,
                                               input logic [31:0] unacked);
        lcsw_row_t row;
        row = COLOUR_ROWS[ROW_COUNT-1];
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (avg <= {22'b0, COLOUR_ROWS[i].rtt_limit}) begin
                row = COLOUR_ROWS[i];
            end
        end
        if (unacked <= {24'b0, row.green_max}) begin
            return COLOUR_GREEN;
        end else if (unacked <= {24'b0, row.yellow_max}) begin
            return COLOUR_YELLOW;
        end
        return COLOUR_RED;
    endfunction

endpackage

### rtl/lcsw_div.sv
// ----------------------------------------------------------------------------
// lcsw_div
// Shared restoring divider: one quotient bit per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
module lcsw_div
    import lcsw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [7:0]       divisor,
    input  logic [5:0]       steps,
    output lcsw_div_status_t status,
    output logic [31:0]      quotient,
    output logic [7:0]       remainder
);

    logic [31:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;
    logic [8:0]  diff;

    // One compare and subtract step
    always_comb begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, dsr_reg};
    end

    // Load on start, shift one bit per cycle while busy
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = 8'd0;
            dsr_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[7:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

### rtl/lcsw_seq.sv
// ----------------------------------------------------------------------------
// lcsw_seq
// Sequencer: period check, optional average divide, then commit of results.
// ----------------------------------------------------------------------------
module lcsw_seq
    import lcsw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  lcsw_div_status_t div_status,
    input  logic             rem_zero,
    input  logic             out_room,
    output logic             s_ready,
    output lcsw_ctrl_t       ctrl
);

    lcsw_state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_status.done) begin
                    state_next = rem_zero ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl.start_mod = 1'b0;
        ctrl.start_div = 1'b0;
        ctrl.commit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                ctrl.start_mod = s_valid;
            end
            ST_MOD: begin
                ctrl.start_div = div_status.done && rem_zero;
            end
            ST_DIV: begin
            end
            ST_FINISH: begin
                ctrl.commit = out_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/link_congestion_send_window_unit.sv
// ----------------------------------------------------------------------------
// link_congestion_send_window_unit
// Per-sample link status tracking with periodic average, colouring and
// send count adjustment.
// ----------------------------------------------------------------------------
//  channel   | ports                         | moves
//  ----------+-------------------------------+------------------------------
//  input     | s_valid s_ready s_payload     | one status sample
//  result    | m_valid m_ready m_payload     | one result per sample
//  config    | psel penable pwrite paddr ... | register write/read, 0/4/8
//
//  A sample that does not close a period runs the period check on the shared
//  divider, then its commit. A closing sample also runs the 32-bit average
//  divide on that divider before its commit. The divider produces one
//  quotient bit per cycle while it is busy with either job.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A stalled result holds in the output register while the next sample is
//  taken; that sample then waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module link_congestion_send_window_unit
    import lcsw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input samples
    input  logic        s_valid,
    output logic        s_ready,
    input  lcsw_in_t    s_payload,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output lcsw_out_t   m_payload,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [7:0]  sample_count_reg;
    logic [15:0] min_send_count_reg;
    logic [15:0] max_send_count_reg;

    // Block state
    logic [7:0]  sample_counter_reg, sample_counter_next;
    logic [31:0] rtt_acc_reg, rtt_acc_next;
    logic [31:0] unacked_acc_reg, unacked_acc_next;
    logic [31:0] pending_acc_reg, pending_acc_next;
    logic [15:0] send_count_reg, send_count_next;
    logic [1:0]  prev_colour_reg, prev_colour_next;
    logic [15:0] min_rtt_reg, min_rtt_next;
    logic [15:0] max_rtt_reg, max_rtt_next;
    logic        close_reg;

    lcsw_in_t    sample_reg;
    logic        m_valid_reg, m_valid_next;
    lcsw_out_t   m_payload_reg;

    lcsw_ctrl_t       ctrl;
    lcsw_div_status_t div_status;
    logic [31:0]      div_quotient;
    logic [7:0]       div_remainder;
    logic             div_start;
    logic [31:0]      div_dividend;
    logic [5:0]       div_steps;
    logic [7:0]       period;
    logic [7:0]       counter_inc;
    logic             out_room;
    logic             cfg_write;

    logic [1:0]  colour;
    logic [15:0] half;
    logic [16:0] dbl;
    logic [15:0] send_eval;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg   <= 8'd8;
            min_send_count_reg <= 16'd1;
            max_send_count_reg <= 16'd64;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SAMPLE_COUNT:   sample_count_reg   <= pwdata[7:0];
                REG_MIN_SEND_COUNT: min_send_count_reg <= pwdata[15:0];
                REG_MAX_SEND_COUNT: max_send_count_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLE_COUNT:   prdata = {24'b0, sample_count_reg};
            REG_MIN_SEND_COUNT: prdata = {16'b0, min_send_count_reg};
            REG_MAX_SEND_COUNT: prdata = {16'b0, max_send_count_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Sequencer
    assign out_room = !m_valid_reg || m_ready;

    lcsw_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .div_status (div_status),
        .rem_zero   (div_remainder == 8'd0),
        .out_room   (out_room),
        .s_ready    (s_ready),
        .ctrl       (ctrl)
    );

    // Shared divider: period check first, then the average when closing
    assign period      = (sample_count_reg == 8'd0) ? 8'd1 : sample_count_reg;
    assign counter_inc = sample_counter_reg + 8'd1;
    assign div_start   = ctrl.start_mod || ctrl.start_div;

    always_comb begin
        if (ctrl.start_mod) begin
            div_dividend = {counter_inc, 24'b0};
            div_steps    = MOD_STEPS;
        end else begin
            div_dividend = rtt_acc_reg;
            div_steps    = DIV_STEPS;
        end
    end

    lcsw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (period),
        .steps     (div_steps),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Hold the accepted sample and the closing decision
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_reg <= 1'b0;
        end else if (ctrl.start_mod) begin
            close_reg <= 1'b0;
        end else if (ctrl.start_div) begin
            close_reg <= 1'b1;
        end
    end

    // Colour the link and pick the new send count
    always_comb begin
        colour = pick_colour(div_quotient, unacked_acc_reg);
        half   = {1'b0, send_count_reg[15:1]};
        dbl    = {send_count_reg, 1'b0};
        if (colour == COLOUR_GREEN) begin
            send_eval = (half >= min_send_count_reg) ? half : min_send_count_reg;
        end else if (colour == COLOUR_YELLOW && prev_colour_reg != COLOUR_RED) begin
            send_eval = (dbl <= {1'b0, max_send_count_reg}) ? dbl[15:0]
                                                             : max_send_count_reg;
        end else if (colour == COLOUR_YELLOW) begin
            send_eval = max_send_count_reg;
        end else begin
            send_eval = 16'd1;
        end
    end

    // Next state of the tracked values
    always_comb begin
        if (close_reg) begin
            sample_counter_next = 8'd0;
            rtt_acc_next        = div_quotient;
            send_count_next     = send_eval;
            prev_colour_next    = colour;
            unacked_acc_next    = {16'b0, sample_reg.unacked_sample};
            pending_acc_next    = {16'b0, sample_reg.pending_sample};
        end else begin
            sample_counter_next = counter_inc;
            rtt_acc_next        = sat_add(rtt_acc_reg, sample_reg.round_trip_sample);
            send_count_next     = send_count_reg;
            prev_colour_next    = prev_colour_reg;
            unacked_acc_next    = sat_add(unacked_acc_reg, sample_reg.unacked_sample);
            pending_acc_next    = sat_add(pending_acc_reg, sample_reg.pending_sample);
        end
        if (sample_reg.round_trip_sample < min_rtt_reg || min_rtt_reg == 16'd0) begin
            min_rtt_next = sample_reg.round_trip_sample;
        end else begin
            min_rtt_next = min_rtt_reg;
        end
        if (sample_reg.round_trip_sample > max_rtt_reg) begin
            max_rtt_next = sample_reg.round_trip_sample;
        end else begin
            max_rtt_next = max_rtt_reg;
        end
    end

    // Commit state once the result register has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_counter_reg <= 8'd0;
            rtt_acc_reg        <= 32'd0;
            unacked_acc_reg    <= 32'd0;
            pending_acc_reg    <= 32'd0;
            send_count_reg     <= 16'd1;
            prev_colour_reg    <= COLOUR_GREEN;
            min_rtt_reg        <= 16'd0;
            max_rtt_reg        <= 16'd0;
        end else if (ctrl.commit) begin
            sample_counter_reg <= sample_counter_next;
            rtt_acc_reg        <= rtt_acc_next;
            unacked_acc_reg    <= unacked_acc_next;
            pending_acc_reg    <= pending_acc_next;
            send_count_reg     <= send_count_next;
            prev_colour_reg    <= prev_colour_next;
            min_rtt_reg        <= min_rtt_next;
            max_rtt_reg        <= max_rtt_next;
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_payload_reg.send_count     <= send_count_next;
            m_payload_reg.link_colour    <= prev_colour_next;
            m_payload_reg.evaluated      <= close_reg;
            m_payload_reg.min_round_trip <= min_rtt_next;
            m_payload_reg.max_round_trip <= max_rtt_next;
            m_payload_reg.unacked_total  <= unacked_acc_next;
            m_payload_reg.pending_total  <= pending_acc_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // No new sample while the shared divider is working
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> !s_ready)
        else $error("sample accepted while divider busy");

    // An accepted sample blocks the input until its result is committed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after accept");

    // A closing commit clears the sample counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.commit && close_reg) |=> (sample_counter_reg == 8'd0))
        else $error("counter not cleared after period close");

    // Commit never overwrites a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");
`endif

endmodule
